/* design/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared constants and types for the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_W      = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVELS      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = 5;

    typedef logic signed [DATA_W-1:0] t_value;
    typedef logic [FILL_W-1:0]        t_fill;
    typedef logic [QUEUE_DEPTH-1:0]   t_vec;

    localparam logic [1:0] ACT_APPEND   = 2'd0;
    localparam logic [1:0] ACT_PRIORITY = 2'd1;
    localparam logic [1:0] ACT_REMOVE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam t_value THRESHOLD_RESET = t_value'(60);

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        logic   tail_mode;
        t_value value;
        t_value thr;
    } t_cell_ctl;

endpackage

/* design/tcpq_cell.sv */
// ----------------------------------------------------------------------------
// tcpq_cell
// One queue slot: holds a value, flags whether it belongs to the leading run
// ahead of a new entry, and shifts left/right with its neighbours.
// ----------------------------------------------------------------------------
module tcpq_cell (
    input  logic                 i_clk,
    input  tcpq_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_valid,
    input  logic                 i_before,
    input  tcpq_pkg::t_value     i_left_value,
    input  tcpq_pkg::t_value     i_right_value,
    output tcpq_pkg::t_value     o_value,
    output logic                 o_match
);

    tcpq_pkg::t_value r_value;
    tcpq_pkg::t_value n_value;

    assign o_match = i_valid &
                     (i_ctl.tail_mode | ((r_value >= i_ctl.thr) && (r_value >= i_ctl.value)));

    always_comb begin
        n_value = r_value;
        if (i_ctl.rem) begin
            n_value = i_right_value;
        end else if (i_ctl.ins) begin
            if (!i_before) begin
                n_value = i_left_value;
            end else if (!o_match) begin
                n_value = i_ctl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* design/two_class_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_core
// Bounded queue of signed values built as a row of shifting cells; plain
// append, two-class priority insert and head removal.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | i_in_valid, o_in_stall, i_action, i_value | in
//   out      | o_out_valid, i_out_stall, o_removed_value,| out
//            | o_removed_valid, o_status, o_occupancy    |
//   cfg      | i_cfg_wr_en, i_cfg_wr_data (threshold)    | in
//
// One beat per cycle while the output is not stalled: every cell compares
// itself in parallel, a log-depth prefix AND finds the insertion point, and
// all cells shift together. The result is registered for the next cycle;
// a new beat may enter at the edge where the previous result is taken.
// Reset (synchronous) empties the queue and sets the threshold to 60.
// A stalled result holds and stalls the input side until it is taken.
// ----------------------------------------------------------------------------
module two_class_priority_queue_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_action,
    input  tcpq_pkg::t_value      i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcpq_pkg::t_value      o_removed_value,
    output logic                  o_removed_valid,
    output logic [1:0]            o_status,
    output logic [tcpq_pkg::OCC_W-1:0] o_occupancy,
    input  logic                  i_cfg_wr_en,
    input  tcpq_pkg::t_value      i_cfg_wr_data
);

    localparam int N = tcpq_pkg::QUEUE_DEPTH;

    tcpq_pkg::t_value  r_thr;
    tcpq_pkg::t_fill   r_fill;
    tcpq_pkg::t_fill   n_fill;
    logic              r_out_valid;
    tcpq_pkg::t_value  r_removed_value;
    logic              r_removed_valid;
    logic [1:0]        r_status;
    // occupancy register follows the fill count of the last beat
    logic [tcpq_pkg::OCC_W-1:0] r_occupancy;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_is_ins;
    logic              w_is_rem;
    tcpq_pkg::t_cell_ctl w_ctl;
    tcpq_pkg::t_vec    w_valid;
    tcpq_pkg::t_vec    w_match;
    tcpq_pkg::t_vec    w_before;
    tcpq_pkg::t_value  w_cell_value [N];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_full     = (r_fill == tcpq_pkg::t_fill'(N));
    assign w_empty    = (r_fill == '0);
    assign w_is_ins   = (i_action == tcpq_pkg::ACT_APPEND) ||
                        (i_action == tcpq_pkg::ACT_PRIORITY);
    assign w_is_rem   = (i_action == tcpq_pkg::ACT_REMOVE);

    always_comb begin
        w_ctl.ins       = w_accept & w_is_ins & ~w_full;
        w_ctl.rem       = w_accept & w_is_rem & ~w_empty;
        w_ctl.tail_mode = (i_action == tcpq_pkg::ACT_APPEND) || (i_value < r_thr);
        w_ctl.value     = i_value;
        w_ctl.thr       = r_thr;
    end

    // cell i is ahead of the insertion point when every earlier cell matches
    always_comb begin
        tcpq_pkg::t_vec v;
        v = {w_match[N-2:0], 1'b1};
        for (int lvl = 0; lvl < tcpq_pkg::LEVELS; lvl++) begin
            v = v & ~((~v) << (1 << lvl));
        end
        w_before = v;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        tcpq_pkg::t_value w_left;
        tcpq_pkg::t_value w_right;

        assign w_valid[i] = (tcpq_pkg::t_fill'(i) < r_fill);
        assign w_left     = (i == 0) ? i_value : w_cell_value[(i == 0) ? 0 : i-1];
        assign w_right    = (i == N-1) ? w_cell_value[i] : w_cell_value[(i == N-1) ? i : i+1];

        tcpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (w_valid[i]),
            .i_before      (w_before[i]),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .o_value       (w_cell_value[i]),
            .o_match       (w_match[i])
        );
    end

    always_comb begin
        n_fill = r_fill;
        if (w_ctl.ins) begin
            n_fill = r_fill + tcpq_pkg::t_fill'(1);
        end else if (w_ctl.rem) begin
            n_fill = r_fill - tcpq_pkg::t_fill'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= tcpq_pkg::THRESHOLD_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_fill <= n_fill;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed_value <= w_ctl.rem ? w_cell_value[0] : '0;
            r_removed_valid <= w_ctl.rem;
            if (w_is_ins && w_full) begin
                r_status <= tcpq_pkg::ST_FULL;
            end else if (w_is_rem && w_empty) begin
                r_status <= tcpq_pkg::ST_EMPTY;
            end else begin
                r_status <= tcpq_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_occupancy <= tcpq_pkg::OCC_W'(n_fill);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed_value;
    assign o_removed_valid = r_removed_valid;
    assign o_status        = r_status;
    assign o_occupancy     = r_occupancy;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= tcpq_pkg::t_fill'(N))
        else $error("fill count beyond depth");

    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_rem && w_empty) |=>
            (o_status == tcpq_pkg::ST_EMPTY) && !o_removed_valid)
        else $error("remove on empty not flagged");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_ins && !w_full) |=> (r_fill == $past(r_fill) + tcpq_pkg::t_fill'(1)))
        else $error("insert did not grow the queue");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_removed_valid) |-> (o_status == tcpq_pkg::ST_OK))
        else $error("popped beat carries an error status");

endmodule
